>>> hdl/edfs_pkg.sv
package edfs_pkg;

  localparam int unsigned ThreadSlots  = 32;
  localparam int unsigned SlotW        = $clog2(ThreadSlots);
  localparam int unsigned RingDepth    = 64;
  localparam int unsigned RingW        = $clog2(RingDepth);
  localparam logic [31:0] AllOnes      = 32'hFFFF_FFFF;

  // Event codes.
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ADD     = 3'd1,
    OP_EXIT    = 3'd2,
    OP_DELAY   = 3'd3,
    OP_ENQ     = 3'd4,
    OP_DEQ     = 3'd5,
    OP_SCHED   = 3'd6,
    OP_NONE    = 3'd7
  } opcode_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM,
    ST_SCAN,
    ST_MUL,
    ST_DEQ,
    ST_OUT
  } state_e;

  // Contents of one thread slot.
  typedef struct packed {
    logic        used;
    logic [31:0] act;
    logic [31:0] rel;
    logic [31:0] dly;
    logic [31:0] per;
  } slot_t;

  // Command broadcast to all cells.
  typedef struct packed {
    logic        shift;     // rotate the chain by one cell
    logic        wr_add;    // head cell takes a new thread
    logic        wr_exit;   // head cell advances its activation
    logic        wr_delay;  // head cell sets its delay
    logic        wr_arm;    // head cell arms the server
    logic [31:0] now;
    logic [31:0] rel;
    logic [31:0] per;
    logic [31:0] dly;
  } cell_cmd_t;

  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegInvBw = 1'b0;

endpackage

>>> hdl/edfs_cell.sv
module edfs_cell
  import edfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  slot_t     rst_val_i,
  input  logic      is_head_i,
  input  cell_cmd_t cmd_i,
  input  slot_t     prev_i,
  output slot_t     slot_o
);

  slot_t slot_q, slot_d;
  logic [32:0] sum;

  // Saturating activation advance for exit.
  assign sum = {1'b0, slot_q.act} + {1'b0, slot_q.per};

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.shift) begin
      slot_d = prev_i;
    end else if (is_head_i) begin
      if (cmd_i.wr_add) begin
        slot_d.used = 1'b1;
        slot_d.rel  = cmd_i.rel;
        slot_d.per  = cmd_i.per;
        slot_d.act  = cmd_i.now;
        slot_d.dly  = cmd_i.now;
      end
      if (cmd_i.wr_exit) begin
        slot_d.act = sum[32] ? AllOnes : sum[31:0];
      end
      if (cmd_i.wr_delay) begin
        slot_d.dly = cmd_i.dly;
      end
      if (cmd_i.wr_arm) begin
        slot_d.act = cmd_i.now;
        slot_d.rel = cmd_i.rel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= rst_val_i;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

>>> hdl/edfs_chain.sv
module edfs_chain
  import edfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  output slot_t     head_o
);

  // Cell 0 is the head; the chain rotates toward lower cells so that after
  // ThreadSlots shifts every slot is back in place.
  slot_t cells [ThreadSlots];

  for (genvar g = 0; g < ThreadSlots; g++) begin : g_cell
    slot_t rv;
    always_comb begin
      rv.used = (g < 2);
      rv.act  = (g == 1) ? AllOnes : 32'd0;
      rv.rel  = (g < 2) ? AllOnes : 32'd0;
      rv.dly  = 32'd0;
      rv.per  = (g < 2) ? AllOnes : 32'd0;
    end
    edfs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rst_val_i (rv),
      .is_head_i (g == 0),
      .cmd_i     (cmd_i),
      .prev_i    (cells[(g + 1) % ThreadSlots]),
      .slot_o    (cells[g])
    );
  end

  assign head_o = cells[0];

endmodule

>>> hdl/edf_scheduler_with_bandwidth_server_unit.sv
// Event flow: tick and schedule run one schedule pass over the cell chain; exit
// and delay run a scan pass and then a schedule pass; add runs a scan pass only;
// enqueue and dequeue wait for the registered product or ring read, then access the
// job ring; an unused opcode answers straight from idle. Throughput: one event at a time,
// accepted again once the result beat leaves; slot passes rotate the chain once per slot.
// Reset (rst_ni low, asynchronous) restores the slot table, tick count, ring
// pointers and inverse bandwidth; the job ring memory is not cleared.
module edf_scheduler_with_bandwidth_server_unit
  import edfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // opcode[2:0], rel_deadline_in[34:3], period_in[66:35], amount[82:67],
  // task_tag[90:83], zero pad [95:91]
  input  logic [95:0]         s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // next_thread[4:0], switch_needed[5], accepted[6], assigned_slot[11:7],
  // job_deadline[43:12], job_tag_out[51:44], zero pad [55:52]
  output logic [55:0]         m_axis_tdata_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW+1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  state_e state_q, state_d;
  logic [2:0]       op_q;
  logic [31:0]      rel_q, per_q;
  logic [15:0]      amt_q;
  logic [7:0]       tag_q;
  logic [15:0]      invbw_q;
  logic [31:0]      tick_q, tick_d;
  logic [SlotW-1:0] cur_q, cur_d;
  logic             cur_vld_q, cur_vld_d;
  logic [RingW-1:0] head_q, head_d, tail_q, tail_d;
  logic [31:0]      last_q, last_d;
  logic [SlotW:0]   cnt_q, cnt_d;
  logic [SlotW-1:0] best_q, best_d;
  logic [31:0]      early_q, early_d;
  logic             found_q, found_d;
  logic [31:0]      prod_q;
  logic [55:0]      out_q, out_d;
  logic             out_vld_q, out_vld_d;
  logic [39:0]      ring_mem [RingDepth];
  logic [39:0]      ring_rd_q;
  logic             ring_we;
  logic [39:0]      ring_wd;
  cell_cmd_t        cmd;
  slot_t            hd;
  logic [31:0]      dl, base, jdl;
  logic             elig, ring_full, ring_empty, take;
  logic [SlotW-1:0] pos;
  logic             cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CfgAddrW+1:2] == RegInvBw);
  assign prdata = (paddr[CfgAddrW+1:2] == RegInvBw) ? {16'd0, invbw_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invbw_q <= 16'd1;
    end else if (cfg_wr) begin
      invbw_q <= pwdata[15:0];
    end
  end

  edfs_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .head_o (hd)
  );

  // Job ring memory.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[head_q] <= ring_wd;
    end
    ring_rd_q <= ring_mem[tail_q];
  end

  assign s_axis_tready_o = (state_q == ST_IDLE) && !out_vld_q;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  assign pos        = cnt_q[SlotW-1:0];
  assign ring_full  = ((head_q + RingW'(1)) == tail_q);
  assign ring_empty = (head_q == tail_q);
  assign dl         = hd.act + hd.rel;
  assign elig       = hd.used && (hd.act <= tick_q) && (hd.dly <= tick_q) && (pos != '0);
  assign base       = (tick_q > last_q) ? tick_q : last_q;
  assign jdl        = base + prod_q;

  // Registered product for the enqueue deadline.
  always_ff @(posedge clk_i) begin
    prod_q <= {16'd0, amt_q} * {16'd0, invbw_q};
  end

  // Sequencer: head cell holds slot pos; the chain rotates once per slot visited.
  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    head_d    = head_q;
    tail_d    = tail_q;
    last_d    = last_q;
    cnt_d     = cnt_q;
    best_d    = best_q;
    early_d   = early_q;
    found_d   = found_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    ring_we   = 1'b0;
    ring_wd   = {tag_q, jdl};
    cmd       = '0;
    cmd.now   = tick_q;
    cmd.rel   = rel_q;
    cmd.per   = per_q;
    cmd.dly   = tick_q + {16'd0, amt_q};
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (take) begin
          case (opcode_e'(s_axis_tdata_i[2:0]))
            OP_TICK: begin
              tick_d  = tick_q + 32'd1;
              state_d = ST_ARM;
            end
            OP_ADD, OP_EXIT, OP_DELAY: state_d = ST_SCAN;
            OP_SCHED: state_d = ST_ARM;
            OP_ENQ: state_d = ST_MUL;
            OP_DEQ: state_d = ST_DEQ;
            default: begin
              out_d     = {51'd0, cur_vld_q ? cur_q : SlotW'(0)};
              out_vld_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Add/exit/delay pass, followed by a schedule pass for exit/delay.
        found_d = found_q;
        if (op_q == OP_ADD) begin
          if (!found_q && !hd.used) begin
            cmd.wr_add = 1'b1;
            found_d    = 1'b1;
            best_d     = pos;
          end
        end else if (cur_vld_q && pos == cur_q) begin
          cmd.wr_exit  = (op_q == OP_EXIT);
          cmd.wr_delay = (op_q == OP_DELAY);
        end
        cmd.shift = 1'b0;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        cmd.shift = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == (SlotW+1)'(ThreadSlots - 1)) begin
          if (op_q == OP_ADD) begin
            out_d = {4'd0, 8'd0, 32'd0, found_q ? best_q : SlotW'(0), found_q,
                     1'b0, cur_vld_q ? cur_q : SlotW'(0)};
            out_vld_d = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            cnt_d   = '0;
            state_d = ST_ARM;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_ARM: begin
        // Step 0: idle slot at head; best starts as idle with deadline all ones.
        // Arming of slot 1 happens when it reaches the head.
        if (cnt_q == '0) begin
          best_d  = '0;
          early_d = AllOnes;
          cmd.shift = 1'b1;
          cnt_d   = cnt_q + 1'b1;
        end else begin
          if (pos == SlotW'(1) && !ring_empty && hd.act == AllOnes && !found_q) begin
            cmd.wr_arm = 1'b1;
            cmd.rel    = ring_rd_q[31:0] - tick_q;
            found_d    = 1'b1;
          end else begin
            if (elig && dl <= early_q) begin
              best_d  = pos;
              early_d = dl;
            end
            cmd.shift = 1'b1;
            cnt_d     = cnt_q + 1'b1;
            if (cnt_q == (SlotW+1)'(ThreadSlots - 1)) begin
              cnt_d     = '0;
              found_d   = 1'b0;
              if (elig && dl <= early_q) begin
                cur_d = pos;
              end else begin
                cur_d = best_q;
              end
              cur_vld_d = 1'b1;
              out_d     = {50'd0, (!cur_vld_q || cur_d != cur_q), cur_d};
              out_vld_d = 1'b1;
              state_d   = ST_IDLE;
            end
          end
        end
      end
      ST_MUL: begin
        if (cnt_q == '0) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          if (!ring_full) begin
            ring_we = 1'b1;
            last_d  = jdl;
            head_d  = head_q + RingW'(1);
            out_d   = {4'd0, 8'd0, jdl, SlotW'(0), 1'b1, 1'b0,
                       cur_vld_q ? cur_q : SlotW'(0)};
          end else begin
            out_d   = {51'd0, cur_vld_q ? cur_q : SlotW'(0)};
          end
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_DEQ: begin
        if (cnt_q == '0) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          if (!ring_empty) begin
            tail_d = tail_q + RingW'(1);
            out_d  = {4'd0, ring_rd_q[39:32], ring_rd_q[31:0], SlotW'(0), 1'b1, 1'b0,
                      cur_vld_q ? cur_q : SlotW'(0)};
          end else begin
            out_d  = {51'd0, cur_vld_q ? cur_q : SlotW'(0)};
          end
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q  <= s_axis_tdata_i[2:0];
      rel_q <= s_axis_tdata_i[34:3];
      per_q <= s_axis_tdata_i[66:35];
      amt_q <= s_axis_tdata_i[82:67];
      tag_q <= s_axis_tdata_i[90:83];
    end
    out_q   <= out_d;
    early_q <= early_d;
    best_q  <= best_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tick_q    <= '0;
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      last_q    <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tick_q    <= tick_d;
      cur_q     <= cur_d;
      cur_vld_q <= cur_vld_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      last_q    <= last_d;
      cnt_q     <= cnt_d;
      found_q   <= (state_q == ST_IDLE) ? 1'b0 : found_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input is never taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_vld_q |-> !s_axis_tready_o)
    else $error("input taken while result pending");
  // A result appears only on return to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(out_vld_q) |-> state_q == ST_IDLE)
    else $error("result outside idle");
  // The ring never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ring_we |-> !ring_full)
    else $error("ring overflow");
  // The scan counter stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (SlotW+1)'(ThreadSlots))
    else $error("counter out of range");

endmodule
